### hdl/pber_pkg.sv
// ----------------------------------------------------------------------------
// pber_pkg: shared types and constants for the pad key edge/repeat block
// Key word layout, hat angle sectors, register indexes and the key decoder.
// ----------------------------------------------------------------------------
package pber_pkg;

    localparam int PADS = 4;
    localparam int KEYS = 16;
    localparam int PAD_IDX_W = (PADS > 1) ? $clog2(PADS) : 1;

    localparam int PAD_W = 2;
    localparam int ANGLE_W = 16;
    localparam int BTN_W = 12;
    localparam int CNT_W = 8;
    localparam int CFG_IDX_W = 1;

    typedef logic [KEYS-1:0]  t_keys;
    typedef logic [CNT_W-1:0] t_cnt;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_WAIT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 1'd1;

    localparam t_cnt WAIT_RST     = t_cnt'(20);
    localparam t_cnt INTERVAL_RST = t_cnt'(1);

    // Hat sector bounds, hundredths of a degree, inclusive
    localparam logic [ANGLE_W-1:0] ANG_45  = ANGLE_W'(45 * 100);
    localparam logic [ANGLE_W-1:0] ANG_135 = ANGLE_W'(135 * 100);
    localparam logic [ANGLE_W-1:0] ANG_225 = ANGLE_W'(225 * 100);
    localparam logic [ANGLE_W-1:0] ANG_315 = ANGLE_W'(315 * 100);
    localparam logic [ANGLE_W-1:0] ANG_360 = ANGLE_W'(360 * 100);

    // Key slots: 0 left, 1 right, 2 up, 3 down, 4.. buttons
    function automatic t_keys decode_keys(input logic [ANGLE_W-1:0] angle,
                                          input logic [BTN_W-1:0]   buttons);
        logic [KEYS+BTN_W-1:0] k;
        k = '0;
        k[0] = (angle >= ANG_225) && (angle <= ANG_315);
        k[1] = (angle >= ANG_45)  && (angle <= ANG_135);
        k[2] = ((angle >= ANG_315) && (angle <= ANG_360)) || (angle <= ANG_45);
        k[3] = (angle >= ANG_135) && (angle <= ANG_225);
        k[BTN_W+3:4] = buttons;
        return k[KEYS-1:0];
    endfunction

endpackage

### hdl/pber_key_cell.sv
// ----------------------------------------------------------------------------
// pber_key_cell: auto-repeat counter update for one key
// Next hold count, repeat phase and repeat pulse from the key's held bit.
// ----------------------------------------------------------------------------
module pber_key_cell (
    input  logic              i_held,
    input  pber_pkg::t_cnt    i_cnt,
    input  pber_pkg::t_cnt    i_ph,
    input  pber_pkg::t_cnt    i_wait,
    input  pber_pkg::t_cnt    i_ivl,
    output pber_pkg::t_cnt    o_cnt,
    output pber_pkg::t_cnt    o_ph,
    output logic              o_pulse
);
    import pber_pkg::*;

    t_cnt             cnt_inc;
    logic [CNT_W:0]   ph_inc;

    assign cnt_inc = i_cnt + t_cnt'(1);
    assign ph_inc  = {1'b0, i_ph} + (CNT_W+1)'(1);

    always_comb begin
        o_cnt   = '0;
        o_ph    = '0;
        o_pulse = 1'b0;
        if (i_held) begin
            if (i_cnt < i_wait) begin
                // still counting toward the wait; pulse on first poll and at the wait
                o_cnt   = cnt_inc;
                o_pulse = (cnt_inc < i_wait) ? (cnt_inc == t_cnt'(1)) : 1'b1;
            end else begin
                // steady repeat
                o_cnt = i_cnt;
                if (ph_inc >= {1'b0, i_ivl}) begin
                    o_ph    = '0;
                    o_pulse = 1'b1;
                end else begin
                    o_ph = ph_inc[CNT_W-1:0];
                end
            end
        end
    end

endmodule

### hdl/pad_button_edge_repeat.sv
// ----------------------------------------------------------------------------
// pad_button_edge_repeat: pad key state with edge detect and auto-repeat
// Decodes one pad poll into key words: held, pressed, released, repeat.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: one word per pad poll (pad, hat_angle, button_bits,
//   read_ok), accepted when i_in_valid is high and o_in_stall is low.
//   Output channel: one result word per poll (pad_out, key flag words,
//   fresh), taken when o_out_valid is high and i_out_stall is low.
//   Path: an accepted word passes the input register, then the result
//   register, where o_out_valid rises. Throughput: one poll per cycle
//   while the receiver does not stall; the per-key counter
//   update for the addressed pad is read, updated and written back in the
//   cycle that moves the word into the result register, so back-to-back
//   polls of the same pad see each other's state.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more word, then o_in_stall rises until the result moves.
//   A poll with read_ok low leaves state alone and returns the stored flags
//   with fresh low.
//   Reset (i_rst_n low, synchronous) empties both registers, clears all
//   per-pad key words and per-key counters, and loads repeat_wait = 20 and
//   repeat_interval = 1.
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
//   (0 repeat_wait, 1 repeat_interval); a written zero acts as one.
// ----------------------------------------------------------------------------
module pad_button_edge_repeat (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [pber_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pber_pkg::CNT_W-1:0]          i_cfg_wdata,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pber_pkg::PAD_W-1:0]          i_pad,
    input  logic [pber_pkg::ANGLE_W-1:0]        i_hat_angle,
    input  logic [pber_pkg::BTN_W-1:0]          i_button_bits,
    input  logic                                i_read_ok,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pber_pkg::PAD_W-1:0]          o_pad_out,
    output pber_pkg::t_keys                     o_held_keys,
    output pber_pkg::t_keys                     o_pressed_edges,
    output pber_pkg::t_keys                     o_released_edges,
    output pber_pkg::t_keys                     o_repeat_pulses,
    output logic                                o_fresh
);
    import pber_pkg::*;

    // configuration registers
    t_cnt r_wait;
    t_cnt r_ivl;
    t_cnt eff_wait;
    t_cnt eff_ivl;

    // input register
    logic                 r_in_valid;
    logic [PAD_W-1:0]     r_pad;
    logic [ANGLE_W-1:0]   r_angle;
    logic [BTN_W-1:0]     r_buttons;
    logic                 r_read_ok;

    // result register
    logic                 r_out_valid;
    logic [PAD_W-1:0]     r_pad_out;
    t_keys                r_held_o;
    t_keys                r_rise_o;
    t_keys                r_fall_o;
    t_keys                r_pulse_o;
    logic                 r_fresh;

    // per-pad state
    t_keys r_held  [PADS];
    t_keys r_rise  [PADS];
    t_keys r_fall  [PADS];
    t_keys r_pulse [PADS];
    t_cnt  r_cnt   [PADS][KEYS];
    t_cnt  r_ph    [PADS][KEYS];

    logic                 out_take;
    logic                 in_take;
    logic                 do_step;
    logic                 pad_ok;
    logic                 do_update;
    logic [PAD_IDX_W-1:0] row;
    t_keys                now_keys;
    t_keys                old_keys;
    t_keys                n_pulse;
    t_keys                n_rise;
    t_keys                n_fall;
    t_cnt                 n_cnt [KEYS];
    t_cnt                 n_ph  [KEYS];

    // handshake: result register frees when empty or taken
    assign out_take   = !r_out_valid || !i_out_stall;
    assign in_take    = !r_in_valid || out_take;
    assign o_in_stall = !in_take;
    assign do_step    = r_in_valid && out_take;

    assign eff_wait = (r_wait == '0) ? t_cnt'(1) : r_wait;
    assign eff_ivl  = (r_ivl == '0)  ? t_cnt'(1) : r_ivl;

    assign pad_ok    = (32'(r_pad) < PADS);
    assign row       = PAD_IDX_W'(r_pad);
    assign do_update = do_step && pad_ok && r_read_ok;

    assign now_keys = decode_keys(r_angle, r_buttons);
    assign old_keys = r_held[row];
    assign n_rise   = (old_keys ^ now_keys) & now_keys;
    assign n_fall   = (old_keys ^ now_keys) & ~now_keys;

    for (genvar k = 0; k < KEYS; k++) begin : g_key
        pber_key_cell u_cell (
            .i_held  (now_keys[k]),
            .i_cnt   (r_cnt[row][k]),
            .i_ph    (r_ph[row][k]),
            .i_wait  (eff_wait),
            .i_ivl   (eff_ivl),
            .o_cnt   (n_cnt[k]),
            .o_ph    (n_ph[k]),
            .o_pulse (n_pulse[k])
        );
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait      <= WAIT_RST;
            r_ivl       <= INTERVAL_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int p = 0; p < PADS; p++) begin
                r_held[p]  <= '0;
                r_rise[p]  <= '0;
                r_fall[p]  <= '0;
                r_pulse[p] <= '0;
                for (int k = 0; k < KEYS; k++) begin
                    r_cnt[p][k] <= '0;
                    r_ph[p][k]  <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_REPEAT_WAIT:     r_wait <= i_cfg_wdata;
                    CFG_REPEAT_INTERVAL: r_ivl  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (in_take) begin
                r_in_valid <= i_in_valid;
            end
            if (out_take) begin
                r_out_valid <= r_in_valid;
            end
            if (do_update) begin
                r_held[row]  <= now_keys;
                r_rise[row]  <= n_rise;
                r_fall[row]  <= n_fall;
                r_pulse[row] <= n_pulse;
                for (int k = 0; k < KEYS; k++) begin
                    r_cnt[row][k] <= n_cnt[k];
                    r_ph[row][k]  <= n_ph[k];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_pad     <= i_pad;
            r_angle   <= i_hat_angle;
            r_buttons <= i_button_bits;
            r_read_ok <= i_read_ok;
        end
        if (do_step) begin
            r_pad_out <= r_pad;
            if (!pad_ok) begin
                r_held_o  <= '0;
                r_rise_o  <= '0;
                r_fall_o  <= '0;
                r_pulse_o <= '0;
                r_fresh   <= 1'b0;
            end else if (r_read_ok) begin
                r_held_o  <= now_keys;
                r_rise_o  <= n_rise;
                r_fall_o  <= n_fall;
                r_pulse_o <= n_pulse;
                r_fresh   <= 1'b1;
            end else begin
                // failed read: echo stored flags
                r_held_o  <= r_held[row];
                r_rise_o  <= r_rise[row];
                r_fall_o  <= r_fall[row];
                r_pulse_o <= r_pulse[row];
                r_fresh   <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pad_out        = r_pad_out;
    assign o_held_keys      = r_held_o;
    assign o_pressed_edges  = r_rise_o;
    assign o_released_edges = r_fall_o;
    assign o_repeat_pulses  = r_pulse_o;
    assign o_fresh          = r_fresh;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pad key edge/repeat block
// Streams pad polls through the block under random valid/stall traffic and
// compares every result word against a cycle-free key state predictor kept
// in the bench. Repeat timing is exercised across several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import pber_pkg::*;

    // One poll as it goes into the block
    typedef struct {
        logic [PAD_W-1:0]   pad;
        logic [ANGLE_W-1:0] angle;
        logic [BTN_W-1:0]   btn;
        logic               ok;
    } t_poll;

    // One result word as it comes out
    typedef struct {
        logic [PAD_W-1:0] pad;
        t_keys            held;
        t_keys            rise;
        t_keys            fall;
        t_keys            rep;
        logic             fresh;
    } t_report;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_REPEAT_WAIT;
    logic [CNT_W-1:0]   i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [PAD_W-1:0]   i_pad = '0;
    logic [ANGLE_W-1:0] i_hat_angle = '0;
    logic [BTN_W-1:0]   i_button_bits = '0;
    logic               i_read_ok = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [PAD_W-1:0]   o_pad_out;
    t_keys              o_held_keys;
    t_keys              o_pressed_edges;
    t_keys              o_released_edges;
    t_keys              o_repeat_pulses;
    logic               o_fresh;

    pad_button_edge_repeat i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pad            (i_pad),
        .i_hat_angle      (i_hat_angle),
        .i_button_bits    (i_button_bits),
        .i_read_ok        (i_read_ok),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pad_out        (o_pad_out),
        .o_held_keys      (o_held_keys),
        .o_pressed_edges  (o_pressed_edges),
        .o_released_edges (o_released_edges),
        .o_repeat_pulses  (o_repeat_pulses),
        .o_fresh          (o_fresh)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: per-pad key words, per-key hold count and phase
    // ------------------------------------------------------------------
    t_keys pad_held [PADS];
    t_keys pad_rise [PADS];
    t_keys pad_fall [PADS];
    t_keys pad_rep  [PADS];
    t_cnt  key_hold [PADS][KEYS];
    t_cnt  key_phase[PADS][KEYS];
    t_cnt  rep_wait_cfg = WAIT_RST;
    t_cnt  rep_ivl_cfg  = INTERVAL_RST;

    t_poll   polls_to_send[$];
    t_report expected_reports[$];

    int  bad_reports = 0;
    int  reports_seen = 0;
    bit  in_taken = 1'b0;     // word accepted at the last rising edge
    bit  calm_tail = 1'b0;    // no idling on either side
    int  send_gap = 0;
    int  stall_gap = 0;
    int  long_hold = 0;
    bit  long_hold_done = 1'b0;

    // Hat sectors overlap at the diagonals, so a boundary angle lights two keys
    function automatic t_keys hat_and_buttons(logic [ANGLE_W-1:0] a, logic [BTN_W-1:0] b);
        t_keys k;
        k = '0;
        k[0] = (a >= 16'd22500) && (a <= 16'd31500);
        k[1] = (a >= 16'd4500)  && (a <= 16'd13500);
        k[2] = ((a >= 16'd31500) && (a <= 16'd36000)) || (a <= 16'd4500);
        k[3] = (a >= 16'd13500) && (a <= 16'd22500);
        for (int i = 0; i < BTN_W && i + 4 < KEYS; i++)
            k[i+4] = b[i];
        return k;
    endfunction

    // Advance the predictor by one accepted poll and queue its result word
    function automatic void predict_report(t_poll p);
        t_report r;
        t_keys   now;
        int      w, ivl, cnt, ph;
        bit      pulse;
        r.pad = p.pad;
        if (int'(p.pad) >= PADS) begin
            r.held = '0; r.rise = '0; r.fall = '0; r.rep = '0; r.fresh = 1'b0;
            expected_reports.push_back(r);
            return;
        end
        // a programmed zero behaves as one
        w   = (rep_wait_cfg == 0) ? 1 : int'(rep_wait_cfg);
        ivl = (rep_ivl_cfg == 0) ? 1 : int'(rep_ivl_cfg);
        if (p.ok) begin
            now = hat_and_buttons(p.angle, p.btn);
            pad_rep[p.pad] = '0;
            for (int k = 0; k < KEYS; k++) begin
                cnt = int'(key_hold[p.pad][k]);
                ph  = int'(key_phase[p.pad][k]);
                pulse = 1'b0;
                if (now[k]) begin
                    if (cnt < w) begin
                        // first held poll and the poll reaching the wait both pulse
                        cnt++;
                        ph = 0;
                        pulse = (cnt == 1) || (cnt == w);
                    end else begin
                        // steady repeat; count stays even if the wait was lowered
                        ph++;
                        if (ph >= ivl) ph = 0;
                        pulse = (ph == 0);
                    end
                end else begin
                    cnt = 0;
                    ph = 0;
                end
                key_hold[p.pad][k]  = t_cnt'(cnt);
                key_phase[p.pad][k] = t_cnt'(ph);
                pad_rep[p.pad][k]   = pulse;
            end
            pad_rise[p.pad] = now & ~pad_held[p.pad];
            pad_fall[p.pad] = pad_held[p.pad] & ~now;
            pad_held[p.pad] = now;
        end
        // failed read: stored words come back untouched
        r.held  = pad_held[p.pad];
        r.rise  = pad_rise[p.pad];
        r.fall  = pad_fall[p.pad];
        r.rep   = pad_rep[p.pad];
        r.fresh = p.ok;
        expected_reports.push_back(r);
    endfunction

    function automatic void check_report(t_report got);
        t_report exp_r;
        if (expected_reports.size() == 0) begin
            if (bad_reports < 10)
                $display("error: result word for pad %0d with nothing outstanding", got.pad);
            bad_reports++;
            return;
        end
        exp_r = expected_reports.pop_front();
        if (got.pad !== exp_r.pad || got.held !== exp_r.held || got.rise !== exp_r.rise ||
            got.fall !== exp_r.fall || got.rep !== exp_r.rep || got.fresh !== exp_r.fresh) begin
            if (bad_reports < 10) begin
                $display("error: exp pad %0d held %h rise %h fall %h rep %h fresh %b",
                         exp_r.pad, exp_r.held, exp_r.rise, exp_r.fall, exp_r.rep,
                         exp_r.fresh);
                $display("       got pad %0d held %h rise %h fall %h rep %h fresh %b",
                         got.pad, got.held, got.rise, got.fall, got.rep, got.fresh);
            end
            bad_reports++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: both handshakes are sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_poll   p;
        t_report got;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                p.pad = i_pad; p.angle = i_hat_angle; p.btn = i_button_bits; p.ok = i_read_ok;
                predict_report(p);
            end
            if (o_out_valid && !i_out_stall) begin
                got.pad = o_pad_out; got.held = o_held_keys; got.rise = o_pressed_edges;
                got.fall = o_released_edges; got.rep = o_repeat_pulses; got.fresh = o_fresh;
                check_report(got);
                reports_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: presents polls at the falling edge, holds a stalled word
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_poll p;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // word still waiting: keep it as is
        end else if (send_gap > 0) begin
            i_in_valid <= 1'b0;
            send_gap--;
        end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            send_gap = $urandom_range(0, 15);
        end else if (polls_to_send.size() != 0) begin
            p = polls_to_send.pop_front();
            i_pad         <= p.pad;
            i_hat_angle   <= p.angle;
            i_button_bits <= p.btn;
            i_read_ok     <= p.ok;
            i_in_valid    <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver stall: random bursts, plus one long hold-off so that the
    // block fills up and pushes back on the sender
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (long_hold > 0) begin
            i_out_stall <= 1'b1;
            long_hold--;
        end else if (!long_hold_done && reports_seen >= 150) begin
            i_out_stall <= 1'b1;
            long_hold = 40;
            long_hold_done = 1'b1;
        end else if (stall_gap > 0) begin
            i_out_stall <= 1'b1;
            stall_gap--;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_gap = $urandom_range(0, 15);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_poll(int pad, int angle, int btn, bit ok);
        t_poll p;
        p.pad = PAD_W'(pad); p.angle = ANGLE_W'(angle); p.btn = BTN_W'(btn); p.ok = ok;
        polls_to_send.push_back(p);
    endfunction

    // Angles near sector edges, inside the circle, centered, or anything
    function automatic int pick_angle();
        case ($urandom_range(0, 5))
            0:       return (4500 * $urandom_range(0, 8) + $urandom_range(0, 2) - 1) & 16'hffff;
            1, 2, 3: return $urandom_range(0, 36000);
            4:       return $urandom_range(36001, 65535);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Runs of polls that hold a key pattern on one pad, so the repeat
    // logic gets deep; a few bit flips, failed reads, other-pad polls and
    // fully random noise runs mixed in
    task automatic queue_runs(input int n, input int max_run);
        int left, pad, ang, btn, run;
        bit noise;
        left = n;
        while (left > 0) begin
            pad = $urandom_range(0, 3);
            ang = pick_angle();
            btn = $urandom_range(0, 4095);
            noise = ($urandom_range(0, 9) == 0);
            run = $urandom_range(1, max_run);
            for (int i = 0; i < run && left > 0; i++) begin
                if (noise)
                    add_poll($urandom_range(0, 3), $urandom_range(0, 65535),
                             $urandom_range(0, 4095), $urandom_range(0, 1) != 0);
                else if ($urandom_range(0, 4) == 0)
                    add_poll($urandom_range(0, 3), pick_angle(), $urandom_range(0, 4095),
                             $urandom_range(0, 15) != 0);
                else begin
                    if ($urandom_range(0, 7) == 0) btn ^= 1 << $urandom_range(0, 11);
                    if ($urandom_range(0, 15) == 0) ang = pick_angle();
                    add_poll(pad, ang, btn, $urandom_range(0, 15) != 0);
                end
                left--;
            end
        end
    endtask

    // Registers change only with the block empty
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = t_cnt'(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_REPEAT_WAIT) rep_wait_cfg = t_cnt'(val);
        else rep_ivl_cfg = t_cnt'(val);
    endtask

    // Wait until every poll went in and every result came out
    task automatic drain();
        while (polls_to_send.size() != 0 || i_in_valid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        for (int p = 0; p < PADS; p++) begin
            pad_held[p] = '0; pad_rise[p] = '0; pad_fall[p] = '0; pad_rep[p] = '0;
            for (int k = 0; k < KEYS; k++) begin
                key_hold[p][k] = '0;
                key_phase[p][k] = '0;
            end
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: wait 20, interval 1. Hat edges, including the
        // diagonal overlaps and the centered range, then button extremes,
        // failed reads and a short hold/release on one pad.
        add_poll(0, 0, 0, 1);
        add_poll(0, 4500, 0, 1);
        add_poll(0, 4501, 0, 1);
        add_poll(0, 13500, 0, 1);
        add_poll(0, 13501, 0, 1);
        add_poll(0, 22500, 0, 1);
        add_poll(0, 22501, 0, 1);
        add_poll(0, 31499, 0, 1);
        add_poll(0, 31500, 0, 1);
        add_poll(0, 36000, 0, 1);
        add_poll(0, 36001, 0, 1);
        add_poll(0, 65535, 12'hfff, 1);
        add_poll(1, 40000, 12'haaa, 1);
        add_poll(1, 40000, 12'h555, 1);
        add_poll(2, 9000, 12'hfff, 0);
        add_poll(1, 18000, 12'h000, 0);
        add_poll(3, 65535, 12'hfff, 1);
        add_poll(3, 65535, 12'hfff, 1);
        add_poll(3, 65535, 12'hfff, 1);
        add_poll(3, 36001, 12'h000, 1);
        add_poll(0, 27000, 12'h800, 0);
        queue_runs(250, 30);
        drain();

        // Shortest wait and interval: every held poll repeats
        write_reg(CFG_REPEAT_WAIT, 1);
        write_reg(CFG_REPEAT_INTERVAL, 1);
        queue_runs(200, 12);
        drain();

        // Longest wait and interval: one long hold on pad 0 to get past it
        write_reg(CFG_REPEAT_WAIT, 255);
        write_reg(CFG_REPEAT_INTERVAL, 255);
        for (int i = 0; i < 300; i++) add_poll(0, 9000, 12'h801, 1);
        add_poll(0, 9000, 12'h801, 0);
        drain();

        // Both lowered while pad 0 keys are still held: count stays above
        // the new wait and the phase wraps on the next held poll
        write_reg(CFG_REPEAT_WAIT, 5);
        write_reg(CFG_REPEAT_INTERVAL, 3);
        for (int i = 0; i < 30; i++) add_poll(0, 9000, 12'h801, 1);
        queue_runs(220, 40);
        drain();

        // Zero in both registers acts as one
        write_reg(CFG_REPEAT_WAIT, 0);
        write_reg(CFG_REPEAT_INTERVAL, 0);
        queue_runs(250, 20);
        drain();

        // Closing stretch at full rate, no idling either side
        write_reg(CFG_REPEAT_WAIT, 3);
        write_reg(CFG_REPEAT_INTERVAL, 2);
        calm_tail = 1'b1;
        queue_runs(300, 25);
        drain();

        repeat (8) @(posedge i_clk);
        if (bad_reports == 0 && expected_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

endmodule

### sim.f
hdl/pber_pkg.sv
hdl/pber_key_cell.sv
hdl/pad_button_edge_repeat.sv
verif/tb_top.sv
